[src/three_link_arm_inertia_gravity_unit_assert.svh]
// Assertion macros for the three-link arm inertia and gravity unit.
`ifndef THREE_LINK_ARM_INERTIA_GRAVITY_UNIT_ASSERT_SVH
`define THREE_LINK_ARM_INERTIA_GRAVITY_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TLAIG_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlaig assertion failed");

// Next-cycle implication, checked during reset too.
`define TLAIG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tlaig assertion failed");

`endif

[src/tlaig_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlaig_pkg
// Widths, fixed coefficients, arctangent table and payload types shared by
// the arm inertia and gravity unit.
// ----------------------------------------------------------------------------
package tlaig_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int RESULT_BITS  = 32;
  localparam int FRAC_BITS    = ANGLE_BITS - 3;
  localparam int SUM_W        = ANGLE_BITS + 2;
  localparam int PROD_W       = SUM_W + 31;
  localparam int TRIG_W       = 32;
  localparam int XY_W         = 34;
  localparam int Z_W          = 33;
  localparam int CORDIC_STEPS = 30;
  localparam int NUM_TRIG     = 6;

  localparam logic [29:0] INV_TWO_PI_Q32  = 30'd683565276;
  localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

  localparam logic signed [31:0] K_A3 = 32'sd8279439;
  localparam logic signed [31:0] K_A5 = 32'sd3206475;
  localparam logic signed [31:0] K_A6 = 32'sd2734935;
  localparam logic signed [31:0] K_B1 = 32'sd474362122;
  localparam logic signed [31:0] K_B2 = 32'sd238886157;
  localparam logic signed [31:0] K_B3 = 32'sd92516233;

  // constant parts, already scaled to Q54
  localparam logic signed [63:0] C_A124 = 64'sd25026717 <<< 30;
  localparam logic signed [63:0] C_A24  = 64'sd8992983 <<< 30;
  localparam logic signed [63:0] C_A4   = 64'sd3269061 <<< 30;

  typedef struct packed {
    logic signed [TRIG_W-1:0] c1;
    logic signed [TRIG_W-1:0] c2;
    logic signed [TRIG_W-1:0] c12;
    logic signed [TRIG_W-1:0] s0;
    logic signed [TRIG_W-1:0] s01;
    logic signed [TRIG_W-1:0] s012;
  } trig_t;

  typedef struct packed {
    logic signed [RESULT_BITS-1:0] inertia_00;
    logic signed [RESULT_BITS-1:0] inertia_01;
    logic signed [RESULT_BITS-1:0] inertia_02;
    logic signed [RESULT_BITS-1:0] inertia_11;
    logic signed [RESULT_BITS-1:0] inertia_12;
    logic signed [RESULT_BITS-1:0] inertia_22;
    logic signed [RESULT_BITS-1:0] gravity_base;
    logic signed [RESULT_BITS-1:0] gravity_middle;
    logic signed [RESULT_BITS-1:0] gravity_tip;
  } result_t;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[src/tlaig_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlaig_cordic
// One pipelined CORDIC lane: phase in turns to sine and cosine in Q30.
// ----------------------------------------------------------------------------
module tlaig_cordic (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [31:0]                        phase,
  output logic signed [tlaig_pkg::TRIG_W-1:0]     cos_o,
  output logic signed [tlaig_pkg::TRIG_W-1:0]     sin_o
);
  import tlaig_pkg::*;

  logic [31:0]              q_sum;
  logic [1:0]               q_fold;
  logic [31:0]              r_fold;
  logic signed [XY_W-1:0]   x_in [CORDIC_STEPS];
  logic signed [XY_W-1:0]   y_in [CORDIC_STEPS];
  logic signed [Z_W-1:0]    z_in [CORDIC_STEPS];
  logic [1:0]               q_in [CORDIC_STEPS];
  logic signed [XY_W-1:0]   x_r  [CORDIC_STEPS];
  logic signed [XY_W-1:0]   y_r  [CORDIC_STEPS];
  logic signed [Z_W-1:0]    z_r  [CORDIC_STEPS];
  logic [1:0]               q_r  [CORDIC_STEPS];
  logic signed [XY_W-1:0]   x_f, y_f, nx_f, ny_f;

  // fold the phase into the quadrant around zero
  assign q_sum  = phase + 32'h2000_0000;
  assign q_fold = q_sum[31:30];
  assign r_fold = phase - {q_fold, 30'd0};

  genvar i;
  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
      localparam logic signed [Z_W-1:0] ATAN = $signed({1'b0, atan_turn(i)});
      if (i == 0) begin : g_first
        assign x_in[i] = $signed({{(XY_W-30){1'b0}}, CORDIC_GAIN_Q30});
        assign y_in[i] = '0;
        assign z_in[i] = $signed({r_fold[31], r_fold});
        assign q_in[i] = q_fold;
      end else begin : g_next
        assign x_in[i] = x_r[i-1];
        assign y_in[i] = y_r[i-1];
        assign z_in[i] = z_r[i-1];
        assign q_in[i] = q_r[i-1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          q_r[i] <= q_in[i];
          if (!z_in[i][Z_W-1]) begin
            x_r[i] <= x_in[i] - (y_in[i] >>> i);
            y_r[i] <= y_in[i] + (x_in[i] >>> i);
            z_r[i] <= z_in[i] - ATAN;
          end else begin
            x_r[i] <= x_in[i] + (y_in[i] >>> i);
            y_r[i] <= y_in[i] - (x_in[i] >>> i);
            z_r[i] <= z_in[i] + ATAN;
          end
        end
      end
    end
  endgenerate

  assign x_f  = x_r[CORDIC_STEPS-1];
  assign y_f  = y_r[CORDIC_STEPS-1];
  assign nx_f = -x_f;
  assign ny_f = -y_f;

  // rotate back by the folded quadrant
  always_comb begin
    case (q_r[CORDIC_STEPS-1])
      2'd0: begin
        cos_o = x_f[TRIG_W-1:0];
        sin_o = y_f[TRIG_W-1:0];
      end
      2'd1: begin
        cos_o = ny_f[TRIG_W-1:0];
        sin_o = x_f[TRIG_W-1:0];
      end
      2'd2: begin
        cos_o = nx_f[TRIG_W-1:0];
        sin_o = ny_f[TRIG_W-1:0];
      end
      default: begin
        cos_o = y_f[TRIG_W-1:0];
        sin_o = nx_f[TRIG_W-1:0];
      end
    endcase
  end

endmodule
`default_nettype wire

[src/tlaig_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlaig_front
// Accept angle sets, form the six angle sums as phases and run the CORDIC
// lanes; hand the trig values to the middle queue.
// ----------------------------------------------------------------------------
module tlaig_front (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   push,
  output logic                                        full,
  input  wire logic signed [tlaig_pkg::ANGLE_BITS-1:0] angle_base,
  input  wire logic signed [tlaig_pkg::ANGLE_BITS-1:0] angle_middle,
  input  wire logic signed [tlaig_pkg::ANGLE_BITS-1:0] angle_tip,
  input  wire logic                                   mid_full,
  output logic                                        mid_push,
  output tlaig_pkg::trig_t                            mid_data
);
  import tlaig_pkg::*;

  localparam int FRONT_STAGES = 3 + CORDIC_STEPS;

  logic [FRONT_STAGES-1:0]         valid_r;
  logic                            adv;
  logic                            accept;
  logic signed [ANGLE_BITS-1:0]    a0_r, a1_r, a2_r;
  logic signed [SUM_W-1:0]         t0, t1, t2;
  logic signed [SUM_W-1:0]         sum_w  [NUM_TRIG];
  logic signed [PROD_W-1:0]        prod_r [NUM_TRIG];
  logic [PROD_W-1:0]               rnd_w  [NUM_TRIG];
  logic [31:0]                     phase_r [NUM_TRIG];
  logic signed [TRIG_W-1:0]        trig_w [NUM_TRIG];

  // hold the whole pipe only when its last item cannot leave
  assign adv      = !(valid_r[FRONT_STAGES-1] && mid_full);
  assign full     = !adv;
  assign accept   = push && adv;
  assign mid_push = valid_r[FRONT_STAGES-1] && !mid_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[FRONT_STAGES-2:0], accept};
    end
  end

  assign t0 = SUM_W'(a0_r);
  assign t1 = SUM_W'(a1_r);
  assign t2 = SUM_W'(a2_r);
  assign sum_w[0] = t1;
  assign sum_w[1] = t2;
  assign sum_w[2] = t1 + t2;
  assign sum_w[3] = t0;
  assign sum_w[4] = t0 + t1;
  assign sum_w[5] = t0 + t1 + t2;

  always_ff @(posedge clk) begin
    if (adv) begin
      a0_r <= angle_base;
      a1_r <= angle_middle;
      a2_r <= angle_tip;
    end
  end

  genvar k;
  generate
    for (k = 0; k < NUM_TRIG; k++) begin : g_lane
      assign rnd_w[k] = prod_r[k] + (PROD_W'(1) << (FRAC_BITS - 1));
      always_ff @(posedge clk) begin
        if (adv) begin
          prod_r[k]  <= PROD_W'(sum_w[k]) * $signed({1'b0, INV_TWO_PI_Q32});
          phase_r[k] <= rnd_w[k][FRAC_BITS+31:FRAC_BITS];
        end
      end
      if (k < 3) begin : g_cos
        tlaig_cordic u_cordic (
          .clk   (clk),
          .en    (adv),
          .phase (phase_r[k]),
          .cos_o (trig_w[k]),
          .sin_o ()
        );
      end else begin : g_sin
        tlaig_cordic u_cordic (
          .clk   (clk),
          .en    (adv),
          .phase (phase_r[k]),
          .cos_o (),
          .sin_o (trig_w[k])
        );
      end
    end
  endgenerate

  assign mid_data.c1   = trig_w[0];
  assign mid_data.c2   = trig_w[1];
  assign mid_data.c12  = trig_w[2];
  assign mid_data.s0   = trig_w[3];
  assign mid_data.s01  = trig_w[4];
  assign mid_data.s012 = trig_w[5];

endmodule
`default_nettype wire

[src/tlaig_trig_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlaig_trig_queue
// Two-entry queue of trig value sets between the front and the back.
// ----------------------------------------------------------------------------
module tlaig_trig_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire tlaig_pkg::trig_t push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output tlaig_pkg::trig_t      pop_data
);
  import tlaig_pkg::*;

  trig_t      mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= !wr_r;
      if (do_pop)  rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule
`default_nettype wire

[src/tlaig_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlaig_back
// Weight trig values by the arm coefficients, sum, round and saturate the
// nine results; park them in a two-entry output queue.
// ----------------------------------------------------------------------------
module tlaig_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             mid_empty,
  input  wire tlaig_pkg::trig_t mid_data,
  output logic                  mid_pop,
  input  wire logic             pop,
  output logic                  empty,
  output tlaig_pkg::result_t    out_data
);
  import tlaig_pkg::*;

  localparam int NUM_RES = 9;
  localparam logic signed [63:0] LIM  = (64'sd1 <<< (RESULT_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] MINV = -LIM - 64'sd1;
  localparam logic signed [63:0] HALF = 64'sd1 <<< 37;

  logic [2:0]               valid_r;
  logic                     adv;
  logic signed [63:0]       p_r [NUM_TRIG];
  logic signed [63:0]       s_r [NUM_RES];
  logic signed [63:0]       t_w [NUM_RES];
  logic signed [RESULT_BITS-1:0] f_r [NUM_RES];
  result_t                  res_w;
  result_t                  q_r [2];
  logic                     wr_r, rd_r;
  logic [1:0]               cnt_r;
  logic                     q_full, q_push, q_pop;

  assign q_full  = (cnt_r == 2'd2);
  assign adv     = !(valid_r[2] && q_full);
  assign mid_pop = adv && !mid_empty;
  assign q_push  = valid_r[2] && !q_full;
  assign q_pop   = pop && !empty;
  assign empty   = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[1:0], !mid_empty};
    end
  end

  // products, Q24 by Q30
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0] <= 64'(K_A3) * 64'(mid_data.c1);
      p_r[1] <= 64'(K_A6) * 64'(mid_data.c2);
      p_r[2] <= 64'(K_A5) * 64'(mid_data.c12);
      p_r[3] <= 64'(K_B1) * 64'(mid_data.s0);
      p_r[4] <= 64'(K_B2) * 64'(mid_data.s01);
      p_r[5] <= 64'(K_B3) * 64'(mid_data.s012);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r[0] <= C_A124 + (p_r[2] <<< 1) + (p_r[0] <<< 1) + (p_r[1] <<< 1);
      s_r[1] <= C_A24 + p_r[0] + p_r[2] + (p_r[1] <<< 1);
      s_r[2] <= C_A4 + p_r[2] + p_r[1];
      s_r[3] <= C_A24 + (p_r[1] <<< 1);
      s_r[4] <= C_A4 + p_r[1];
      s_r[5] <= C_A4;
      s_r[6] <= -(p_r[3] + p_r[4] + p_r[5]);
      s_r[7] <= -(p_r[4] + p_r[5]);
      s_r[8] <= -p_r[5];
    end
  end

  genvar j;
  generate
    for (j = 0; j < NUM_RES; j++) begin : g_fin
      assign t_w[j] = (s_r[j] + HALF) >>> 38;
      always_ff @(posedge clk) begin
        if (adv) begin
          if (t_w[j] > LIM) begin
            f_r[j] <= LIM[RESULT_BITS-1:0];
          end else if (t_w[j] < MINV) begin
            f_r[j] <= MINV[RESULT_BITS-1:0];
          end else begin
            f_r[j] <= t_w[j][RESULT_BITS-1:0];
          end
        end
      end
    end
  endgenerate

  assign res_w.inertia_00     = f_r[0];
  assign res_w.inertia_01     = f_r[1];
  assign res_w.inertia_02     = f_r[2];
  assign res_w.inertia_11     = f_r[3];
  assign res_w.inertia_12     = f_r[4];
  assign res_w.inertia_22     = f_r[5];
  assign res_w.gravity_base   = f_r[6];
  assign res_w.gravity_middle = f_r[7];
  assign res_w.gravity_tip    = f_r[8];

  // output queue
  assign out_data = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (q_push) wr_r <= !wr_r;
      if (q_pop)  rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(q_push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) q_r[wr_r] <= res_w;
  end

endmodule
`default_nettype wire

[src/three_link_arm_inertia_gravity_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_link_arm_inertia_gravity_unit
// Inertia matrix entries and gravity terms of a planar three-link arm.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive the three Q3.13 joint angles with push; a
//   transfer happens on a clock edge with push high and full low.
//   Result side is a queue: while empty is low the oldest result (six
//   inertia entries, three gravity terms, Q16.16, saturated) sits on the
//   out_ ports; a transfer happens on an edge with pop high and empty low.
//   Throughput: one angle set per cycle while full is low, set by the fully
//   pipelined CORDIC lanes (30 stages) and multiplier stages.
//   From input transfer until empty drops for that item, a set passes
//   3 phase stages, 30 CORDIC stages, the middle queue, 3 arithmetic
//   stages and the output queue.
//   A two-entry queue separates the trig front from the arithmetic back;
//   when pop stays low the back fills its output queue and holds, then the
//   middle queue fills, then the front holds and raises full.
//   Reset (synchronous, rst_n low) drops every item in flight and empties
//   both queues; there is no other state.
// ----------------------------------------------------------------------------
module three_link_arm_inertia_gravity_unit (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      push,
  output logic                                           full,
  input  wire logic signed [tlaig_pkg::ANGLE_BITS-1:0]   in_angle_base,
  input  wire logic signed [tlaig_pkg::ANGLE_BITS-1:0]   in_angle_middle,
  input  wire logic signed [tlaig_pkg::ANGLE_BITS-1:0]   in_angle_tip,
  output logic                                           empty,
  input  wire logic                                      pop,
  output logic signed [tlaig_pkg::RESULT_BITS-1:0]       out_inertia_00,
  output logic signed [tlaig_pkg::RESULT_BITS-1:0]       out_inertia_01,
  output logic signed [tlaig_pkg::RESULT_BITS-1:0]       out_inertia_02,
  output logic signed [tlaig_pkg::RESULT_BITS-1:0]       out_inertia_11,
  output logic signed [tlaig_pkg::RESULT_BITS-1:0]       out_inertia_12,
  output logic signed [tlaig_pkg::RESULT_BITS-1:0]       out_inertia_22,
  output logic signed [tlaig_pkg::RESULT_BITS-1:0]       out_gravity_base,
  output logic signed [tlaig_pkg::RESULT_BITS-1:0]       out_gravity_middle,
  output logic signed [tlaig_pkg::RESULT_BITS-1:0]       out_gravity_tip
);
  import tlaig_pkg::*;

  // front to middle queue
  logic    mid_push, mid_full;
  trig_t   mid_in;
  // middle queue to back
  logic    mid_pop, mid_empty;
  trig_t   mid_out;
  result_t res;

  // Front: phase conversion and CORDIC lanes, stalls as a whole.
  tlaig_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .angle_base   (in_angle_base),
    .angle_middle (in_angle_middle),
    .angle_tip    (in_angle_tip),
    .mid_full     (mid_full),
    .mid_push     (mid_push),
    .mid_data     (mid_in)
  );

  // Middle queue: decouple the two halves.
  tlaig_trig_queue u_mid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_data (mid_in),
    .full      (mid_full),
    .pop       (mid_pop),
    .empty     (mid_empty),
    .pop_data  (mid_out)
  );

  // Back: coefficient products, sums, rounding, saturation, output queue.
  tlaig_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_data  (mid_out),
    .mid_pop   (mid_pop),
    .pop       (pop),
    .empty     (empty),
    .out_data  (res)
  );

  assign out_inertia_00     = res.inertia_00;
  assign out_inertia_01     = res.inertia_01;
  assign out_inertia_02     = res.inertia_02;
  assign out_inertia_11     = res.inertia_11;
  assign out_inertia_12     = res.inertia_12;
  assign out_inertia_22     = res.inertia_22;
  assign out_gravity_base   = res.gravity_base;
  assign out_gravity_middle = res.gravity_middle;
  assign out_gravity_tip    = res.gravity_tip;

`include "three_link_arm_inertia_gravity_unit_assert.svh"

  // front never pushes into a full middle queue
  `TLAIG_ASSERT_IMPLY(a_mid_push_room, mid_push, !mid_full)
  // back never pops an empty middle queue
  `TLAIG_ASSERT_IMPLY(a_mid_pop_data, mid_pop, !mid_empty)
  // reset leaves no result waiting
  `TLAIG_ASSERT_NEXT(a_reset_empty, !rst_n, empty)
  // input side stalls only while the middle queue is full
  `TLAIG_ASSERT_IMPLY(a_full_cause, full, mid_full)

endmodule
`default_nettype wire
